>>> design/i8dpr_pkg.sv
// shared constants and types of the int8 dot-product requantizer
package i8dpr_pkg;

	localparam int LANES_MAX     = 8;
	localparam int DEFAULT_LANES = 8;
	localparam int ACT_W         = 8;
	localparam int NIB_W         = 4;
	localparam int PROD_W        = 2 * ACT_W;
	localparam int DOT_W         = PROD_W + $clog2(LANES_MAX);
	localparam int ACC_W         = 32;
	localparam int SHIFT_W       = 6;
	localparam int PROD64_W      = 2 * ACC_W;
	localparam int SUM_W         = ACC_W + 2;
	localparam int OUT_W         = 8;
	localparam int QUEUE_DEPTH   = 2;

	// stream widths
	localparam int IN_DATA_W  = 200;
	localparam int OUT_DATA_W = 8;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_OFFSET  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_INT4 = 1'd1;

	// requantisation constants
	localparam logic signed [SHIFT_W:0]   SHIFT_BASE = 7'sd31;
	localparam logic signed [SHIFT_W-1:0] SHIFT_MAX  = 6'sd30;
	localparam logic signed [SUM_W-1:0]   SAT_HI     = 34'sd127;
	localparam logic signed [SUM_W-1:0]   SAT_LO     = -34'sd128;

	// one finished dot product waiting for requantisation
	typedef struct packed {
		logic [ACC_W-1:0]   sum;
		logic [ACC_W-1:0]   mult;
		logic [SHIFT_W-1:0] shift;
	} i8dpr_job_t;

endpackage

>>> design/int8_dot_product_requantizer.sv
// top level of the int8 dot-product requantizer
// usage:
//  - s_* channel takes one k group per transfer: eight activations and eight
//    weights (int8, or signed nibbles when weight_is_int4 is set); tlast marks
//    the final group of an output element, which also carries bias, q31
//    multiplier and shift
//  - m_* channel gives one transfer per output element: the saturated int8
//    value in tdata and the clip flag in tuser
//  - cfg_* channel writes the output offset (index 0) and weight_is_int4
//    (index 1); always ready; the user must keep them written only while
//    the block is idle, which the block itself does not enforce
//  - throughput: one group and one scaled element per cycle unless stalled;
//    the front multiplies in stage one and accumulates in stage two into the
//    queue, the back end registers the q31 multiply, rounding and saturation
//  - a stalled receiver freezes the back end; the two-entry job queue then
//    fills and the front stops only when a final group finds it full
//  - reset clears the accumulator, queue, pipeline valids and both registers
module int8_dot_product_requantizer import i8dpr_pkg::*; #(
	parameter int LANES = DEFAULT_LANES,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// act_bytes[63:0], weight_bytes[127:64], bias_value[159:128],
	// multiplier[191:160], shift_amount[197:192], zero fill
	input  logic [IN_DATA_W-1:0]   s_tdata,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// result_value[7:0]
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// clipped[0]
	output logic                   m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [OUT_W-1:0] out_offset_q;
	logic             int4_q;
	logic             job_push;
	logic             job_full;
	logic             job_pop;
	logic             job_valid;
	i8dpr_job_t       push_job;
	i8dpr_job_t       pop_job;

	// configuration registers, every write transfer is taken at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_offset_q <= '0;
			int4_q       <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OUT_OFFSET:  out_offset_q <= cfg_data[OUT_W-1:0];
				REG_WEIGHT_INT4: int4_q       <= cfg_data[0];
			endcase
		end
	end

	// front: lane products and accumulation
	i8dpr_front #(
		.LANES(LANES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.act_bytes     (s_tdata[63:0]),
		.weight_bytes  (s_tdata[127:64]),
		.last_k        (s_tlast),
		.bias_value    (s_tdata[159:128]),
		.multiplier    (s_tdata[191:160]),
		.shift_amount  (s_tdata[197:192]),
		.weight_is_int4(int4_q),
		.job_push      (job_push),
		.job           (push_job),
		.job_full      (job_full)
	);

	// finished sums wait here for requantisation
	i8dpr_queue #(
		.DEPTH(DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(push_job),
		.full    (job_full),
		.pop     (job_pop),
		.pop_job (pop_job),
		.valid   (job_valid)
	);

	// back: scaling, rounding, zero point and saturation
	i8dpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (pop_job),
		.out_offset(out_offset_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> design/i8dpr_front.sv
// front end: lane multipliers, accumulator and job hand-off
module i8dpr_front import i8dpr_pkg::*; #(
	parameter int LANES = DEFAULT_LANES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        act_bytes,
	input  logic [63:0]        weight_bytes,
	input  logic               last_k,
	input  logic [ACC_W-1:0]   bias_value,
	input  logic [ACC_W-1:0]   multiplier,
	input  logic [SHIFT_W-1:0] shift_amount,
	input  logic               weight_is_int4,
	output logic               job_push,
	output i8dpr_job_t         job,
	input  logic               job_full
);

	logic signed [PROD_W-1:0] prod_d [LANES];
	logic signed [PROD_W-1:0] prod_s1 [LANES];
	logic                     valid_s1;
	logic                     last_s1;
	logic [ACC_W-1:0]         bias_s1;
	logic [ACC_W-1:0]         mult_s1;
	logic [SHIFT_W-1:0]       shift_s1;
	logic [ACC_W-1:0]         acc_q;
	logic signed [DOT_W-1:0]  dot;
	logic [ACC_W-1:0]         acc_next;
	logic                     stall;

	always_comb begin
		logic signed [ACT_W-1:0] a_k;
		logic signed [ACT_W-1:0] w_k;
		for (int k = 0; k < LANES; k++) begin
			a_k = act_bytes[ACT_W*k +: ACT_W];
			if (weight_is_int4) begin
				w_k = {{(ACT_W-NIB_W){weight_bytes[NIB_W*k+NIB_W-1]}},
					weight_bytes[NIB_W*k +: NIB_W]};
			end else begin
				w_k = weight_bytes[ACT_W*k +: ACT_W];
			end
			prod_d[k] = PROD_W'(a_k) * PROD_W'(w_k);
		end
	end

	// a final group cannot leave stage one while the queue is full
	assign stall    = valid_s1 && last_s1 && job_full;
	assign s_tready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && s_tvalid) begin
			prod_s1  <= prod_d;
			last_s1  <= last_k;
			bias_s1  <= bias_value;
			mult_s1  <= multiplier;
			shift_s1 <= shift_amount;
		end
	end

	always_comb begin
		dot = '0;
		for (int k = 0; k < LANES; k++) begin
			dot = dot + DOT_W'(prod_s1[k]);
		end
	end

	assign acc_next = acc_q + ACC_W'(dot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1 && !stall) begin
			acc_q <= last_s1 ? '0 : acc_next;
		end
	end

	assign job_push  = valid_s1 && last_s1 && !job_full;
	assign job.sum   = acc_next + bias_s1;
	assign job.mult  = mult_s1;
	assign job.shift = shift_s1;

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && !stall) |=> (acc_q == '0))
		else $error("accumulator not cleared after final group");

	assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (valid_s1 && last_s1))
		else $error("stalled final group left stage one");

endmodule

>>> design/i8dpr_queue.sv
// short job queue between front and back end
module i8dpr_queue import i8dpr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  i8dpr_job_t push_job,
	output logic       full,
	input  logic       pop,
	output i8dpr_job_t pop_job,
	output logic       valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	i8dpr_job_t       entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_pop  = pop && valid;
	assign pop_job = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

>>> design/i8dpr_back.sv
// back end: q31 scaling, rounding shift, zero point and int8 saturation
module i8dpr_back import i8dpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_pop,
	input  i8dpr_job_t            job,
	input  logic [OUT_W-1:0]      out_offset,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser
);

	logic                       en;
	logic signed [SHIFT_W-1:0]  sh_clamped;
	logic [SHIFT_W-1:0]         rs_d;
	logic                       valid_s1;
	logic signed [PROD64_W-1:0] prod_s1;
	logic [SHIFT_W-1:0]         rs_s1;
	logic [SHIFT_W-1:0]         rsm1_s1;
	logic signed [PROD64_W-1:0] shifted;
	logic                       valid_s2;
	logic [ACC_W-1:0]           scaled_s2;
	logic signed [SUM_W-1:0]    biased;
	logic                       out_valid_q;
	logic [OUT_W-1:0]           result_q;
	logic                       clip_q;

	// whole back end moves together; output register frees it
	assign en      = !out_valid_q || m_tready;
	assign job_pop = en && job_valid;

	assign sh_clamped = ($signed(job.shift) > SHIFT_MAX) ? SHIFT_MAX : $signed(job.shift);
	assign rs_d       = SHIFT_W'(SHIFT_BASE - (SHIFT_W+1)'(sh_clamped));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= job_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= $signed(job.sum) * $signed(job.mult);
			rs_s1   <= rs_d;
			rsm1_s1 <= rs_d - 1'b1;
		end
	end

	// floor shift plus the bit just below the cut gives round-half-up
	assign shifted = prod_s1 >>> rs_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s2 <= shifted[ACC_W-1:0] + ACC_W'(prod_s1[rsm1_s1]);
		end
	end

	assign biased = SUM_W'($signed(scaled_s2)) + SUM_W'($signed(out_offset));

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (biased > SAT_HI) begin
				result_q <= SAT_HI[OUT_W-1:0];
				clip_q   <= 1'b1;
			end else if (biased < SAT_LO) begin
				result_q <= SAT_LO[OUT_W-1:0];
				clip_q   <= 1'b1;
			end else begin
				result_q <= biased[OUT_W-1:0];
				clip_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;
	assign m_tuser  = clip_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s2) |=> out_valid_q)
		else $error("scaled value lost before output register");

	assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> en)
		else $error("job taken while back end stalled");

endmodule
